### rtl/core/cfus_pkg.sv
// Shared types and constants for the CAN firmware update sender.
package cfus_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] elapsed;
    logic        tx_ok;
    logic        rx_valid;
    logic [28:0] rx_ident;
    logic [63:0] rx_payload;
    logic [47:0] image_chunk;
    logic        image_read_ok;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [28:0] tx_ident;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic [2:0]  status;
    logic [6:0]  percent;
    logic [22:0] next_offset;
    logic        busy_res;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  node_address;
    logic        image_is_aux;
    logic [12:0] image_kbytes;
    logic [28:0] ready_frame_id;
    logic [28:0] start_frame_id;
    logic [28:0] data_frame_id;
    logic [28:0] end_frame_id;
  } cfg_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // run one transaction step on the held item
    logic div_start; // begin percent division
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_needed;
  } sts_t;

  // Packets per image block; the sequence number is the low bits of the
  // packet count, so this stays a power of two.
  localparam int unsigned PACKETS_PER_BLOCK = 128;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam logic [3:0] PH_READY  = 4'd0;
  localparam logic [3:0] PH_WREADY = 4'd1;
  localparam logic [3:0] PH_START  = 4'd2;
  localparam logic [3:0] PH_WSTART = 4'd3;
  localparam logic [3:0] PH_BUILD  = 4'd4;
  localparam logic [3:0] PH_SEND   = 4'd5;
  localparam logic [3:0] PH_WDATA  = 4'd6;
  localparam logic [3:0] PH_END    = 4'd7;
  localparam logic [3:0] PH_WEND   = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;
  localparam logic [3:0] PH_NORSP  = 4'd10;
  localparam logic [3:0] PH_RDERR  = 4'd11;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_SENT = 3'd2;
  localparam logic [2:0] ST_OK   = 3'd3;
  localparam logic [2:0] ST_NORSP = 3'd4;
  localparam logic [2:0] ST_RDERR = 3'd5;

  localparam logic [12:0] CTRL_WAIT = 13'd3000;
  localparam logic [12:0] DATA_WAIT = 13'd5000;
  localparam logic [3:0]  CTRL_RETRY_MAX = 4'd10;
  localparam logic [3:0]  DATA_RETRY_MAX = 4'd8;

  localparam logic [2:0] REG_NODE  = 3'd0;
  localparam logic [2:0] REG_AUX   = 3'd1;
  localparam logic [2:0] REG_KB    = 3'd2;
  localparam logic [2:0] REG_READY = 3'd3;
  localparam logic [2:0] REG_START = 3'd4;
  localparam logic [2:0] REG_DATA  = 3'd5;
  localparam logic [2:0] REG_END   = 3'd6;

endpackage

### rtl/core/cfus_div.sv
// Restoring divider for the progress percent: done*100 / (total+1).
module cfus_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [22:0] done_i,
  input  logic [22:0] total_i,
  output logic        busy_o,
  output logic [6:0]  quot_o
);
  logic [29:0] num_q, num_d;
  logic [23:0] den_q, den_d;
  logic [24:0] rem_q, rem_d;
  logic [29:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [24:0] trial;

  assign trial = {rem_q[23:0], num_q[29]};

  // Shift in one numerator bit per cycle.
  always_comb begin
    num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      num_d  = 30'({7'd0, done_i} * 30'd100);
      den_d  = {1'b0, total_i} + 24'd1;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 5'd29;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[28:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[28:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[28:0], 1'b0};
      end
      if (cnt_q == 5'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q[6:0];
endmodule

### rtl/core/cfus_dp.sv
// Datapath: protocol state registers, frame build and echo compare.
module cfus_dp #(
  parameter int unsigned ChunkBytes      = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfus_pkg::cfg_t cfg_i,
  input  cfus_pkg::req_t req_i,
  input  cfus_pkg::cmd_t cmd_i,
  output cfus_pkg::sts_t sts_o,
  output cfus_pkg::rsp_t rsp_o
);
  import cfus_pkg::*;

  localparam int unsigned SeqW = $clog2(PACKETS_PER_BLOCK);

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  retries_q, retries_d;
  logic [15:0] pkt_q, pkt_d;
  logic [22:0] left_q, left_d;
  logic [22:0] off_q, off_d;
  logic [12:0] cd_q, cd_d;
  logic [28:0] id_q, id_d;
  logic [63:0] pl_q, pl_d;
  logic [2:0]  len_q, len_d;
  logic        act_q, act_d;
  logic [6:0]  prog_q, prog_d;
  logic        dneed_q, dneed_d;
  rsp_t        out_q, out_d;
  logic [22:0] done_q, done_d, tot_q, tot_d;
  logic        fix_q;

  logic [22:0] total;
  logic [12:0] kb;
  logic [2:0]  n;
  logic [63:0] nmask, lmask;
  logic [15:0] seq_hi, seq_lo;
  logic [47:0] chunk;
  logic        dsend;
  logic [22:0] left_new;
  logic [6:0]  div_q;
  logic        div_busy;
  logic [2:0]  st;
  logic        fix_pct;
  rsp_t        out_fix;

  assign kb    = (cfg_i.image_kbytes > 13'd4096) ? 13'd4096 : cfg_i.image_kbytes;
  assign total = {kb, 10'd0};

  function automatic logic [63:0] bmask(input logic [2:0] b);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (i < int'(b)) m[8*i +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic logic [28:0] merge(input logic [28:0] base, input logic [7:0] a);
    return base | {13'd0, a, 8'd0};
  endfunction

  assign n = (left_q > 23'(ChunkBytes)) ? 3'(ChunkBytes) : left_q[2:0];
  assign nmask = bmask(n);
  assign lmask = bmask(len_q);
  assign chunk = req_i.image_chunk & nmask[47:0];
  assign seq_hi = 16'(pkt_q >> SeqW) & 16'h00FF;
  assign seq_lo = 16'(pkt_q[SeqW-1:0]);
  assign left_new = (left_q < {20'd0, len_q}) ? 23'd0 : left_q - {20'd0, len_q};

  // Status from the phase after the step.
  function automatic logic [2:0] stat(input logic [3:0] p, input logic a);
    if (p >= 4'd12) return ST_NORSP;
    if (p == PH_RDERR) return ST_RDERR;
    if (p == PH_NORSP) return ST_NORSP;
    if (p == PH_DONE || p == PH_WEND) return ST_OK;
    if (!a) return ST_IDLE;
    if (p == PH_END) return ST_SENT;
    return ST_RUN;
  endfunction

  // Evaluate one transaction.
  always_comb begin
    phase_d = phase_q; retries_d = retries_q; pkt_d = pkt_q; left_d = left_q;
    off_d = off_q; cd_d = cd_q; id_d = id_q; pl_d = pl_q; len_d = len_q;
    act_d = act_q; prog_d = prog_q; dneed_d = 1'b0; out_d = out_q;
    done_d = done_q; tot_d = tot_q;
    dsend = 1'b0;
    if (cmd_i.load) begin
      out_d.tx_valid = 1'b0; out_d.tx_ident = '0; out_d.tx_length = '0;
      out_d.tx_payload = '0;
      unique case (req_i.req_type)
        REQ_START: begin
          phase_d = PH_READY; off_d = '0; left_d = total; retries_d = '0;
          act_d = 1'b1;
        end
        REQ_TICK: cd_d = ({3'd0, cd_q} > req_i.elapsed) ?
                         13'({3'd0, cd_q} - req_i.elapsed) : 13'd0;
        REQ_STEP: begin
          if (act_q) begin
            unique case (phase_q)
              PH_READY, PH_START, PH_END: begin
                if (retries_q > CTRL_RETRY_MAX) begin
                  retries_d = '0; phase_d = PH_NORSP;
                end else begin
                  prog_d = '0; pkt_d = '0;
                  if (phase_q == PH_READY) begin
                    id_d = merge(cfg_i.ready_frame_id, cfg_i.node_address);
                    pl_d = {63'd0, cfg_i.image_is_aux};
                  end else if (phase_q == PH_START) begin
                    id_d = merge(cfg_i.start_frame_id, cfg_i.node_address);
                    pl_d = {63'd0, cfg_i.image_is_aux};
                  end else begin
                    id_d = merge(cfg_i.end_frame_id, cfg_i.node_address);
                    pl_d = 64'd1;
                  end
                  out_d.tx_valid = 1'b1; out_d.tx_ident = id_d;
                  out_d.tx_length = 4'd8; out_d.tx_payload = pl_d;
                  if (req_i.tx_ok) begin
                    phase_d = phase_q + 4'd1; cd_d = CTRL_WAIT;
                  end
                  retries_d = retries_q + 4'd1;
                end
              end
              PH_WREADY, PH_WSTART, PH_WEND: begin
                if (req_i.rx_valid && req_i.rx_ident == id_q && req_i.rx_payload == pl_q) begin
                  phase_d = phase_q + 4'd1; retries_d = '0;
                end else if (cd_q == '0) phase_d = phase_q - 4'd1;
              end
              PH_BUILD: begin
                if (left_q == '0) begin
                  retries_d = '0; phase_d = PH_END;
                end else if (pkt_q[SeqW-1:0] == '0 && !req_i.image_read_ok) begin
                  phase_d = PH_RDERR;
                end else begin
                  len_d = n;
                  id_d  = merge(cfg_i.data_frame_id, cfg_i.node_address);
                  pl_d  = {chunk, seq_lo[7:0], seq_hi[7:0]};
                  retries_d = '0;
                  dsend = 1'b1;
                end
              end
              PH_SEND: dsend = 1'b1;
              PH_WDATA: begin
                if (req_i.rx_valid && req_i.rx_ident == id_q &&
                    ((req_i.rx_payload ^ pl_q) & lmask) == '0) begin
                  pkt_d = pkt_q + 16'd1;
                  off_d = off_q + {20'd0, len_q};
                  left_d = left_new;
                  done_d = (total > left_new) ? total - left_new : 23'd0;
                  tot_d = total;
                  dneed_d = 1'b1;
                  phase_d = PH_BUILD;
                end else if (cd_q == '0) phase_d = PH_SEND;
              end
              default: act_d = 1'b0;
            endcase
            // Data frame send shared by build and resend.
            if (dsend) begin
              if (retries_d > DATA_RETRY_MAX) begin
                retries_d = '0; phase_d = PH_NORSP;
              end else begin
                out_d.tx_valid = 1'b1; out_d.tx_ident = id_d;
                out_d.tx_length = {1'b0, len_d} + 4'd2; out_d.tx_payload = pl_d;
                phase_d = PH_SEND;
                if (req_i.tx_ok) begin
                  cd_d = DATA_WAIT; phase_d = PH_WDATA;
                end
                retries_d = retries_d + 4'd1;
              end
            end
          end
        end
        default: ;
      endcase
      st = stat(phase_d, act_d);
      out_d.status = st;
      out_d.percent = (st == ST_SENT || st == ST_OK) ? 7'd100 : prog_d;
      out_d.next_offset = off_d;
      out_d.busy_res = act_d;
    end else begin
      st = '0;
    end
    if (dneed_q && !div_busy && !cmd_i.div_start) prog_d = div_q;
  end

  // Fix percent into the held result once the division finishes.
  assign fix_pct = dneed_q && !fix_q && !div_busy && !cmd_i.div_start && !cmd_i.load;

  always_comb begin
    out_fix = out_q;
    out_fix.percent = (out_q.status == ST_SENT || out_q.status == ST_OK) ?
                      7'd100 : div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0; retries_q <= '0; pkt_q <= '0; left_q <= '0; off_q <= '0;
      cd_q <= '0; id_q <= '0; pl_q <= '0; len_q <= '0; act_q <= 1'b0;
      prog_q <= '0; dneed_q <= 1'b0; fix_q <= 1'b0;
    end else begin
      phase_q <= phase_d; retries_q <= retries_d; pkt_q <= pkt_d; left_q <= left_d;
      off_q <= off_d; cd_q <= cd_d; id_q <= id_d; pl_q <= pl_d; len_q <= len_d;
      act_q <= act_d;
      if (cmd_i.load) dneed_q <= dneed_d;
      fix_q <= cmd_i.div_start;
      if (fix_pct) prog_q <= div_q;
      else prog_q <= prog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d; tot_q <= tot_d;
    out_q <= fix_pct ? out_fix : out_d;
  end

  cfus_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .done_i  (done_q),
    .total_i (tot_q),
    .busy_o  (div_busy),
    .quot_o  (div_q)
  );

  assign sts_o.div_busy   = div_busy | fix_q;
  assign sts_o.div_needed = dneed_q;
  assign rsp_o = out_q;
endmodule

### rtl/core/cfus_ctrl.sv
// Controller: input and output handshake sequencing.
module cfus_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cfus_pkg::sts_t sts_i,
  output cfus_pkg::cmd_t cmd_o
);
  import cfus_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_KICK, S_DIV, S_FIX, S_OUT} state_e;
  state_e state_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.load    = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.div_start = (state_q == S_KICK) && sts_i.div_needed;

  // Step through load, optional division, then hold result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_KICK;
        S_KICK: state_q <= sts_i.div_needed ? S_DIV : S_OUT;
        S_DIV:  if (!sts_i.div_busy) state_q <= S_FIX;
        S_FIX:  state_q <= S_OUT;
        S_OUT:  if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/can_firmware_update_sender_core.sv
// Top level of the CAN firmware update sender.
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (req_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (rsp_t)
//  cfg     | input     | APB psel/penable/pwrite  | paddr, pwdata, prdata
// One item at a time; items that acknowledge a data packet also run the
// percent divider (one quotient bit per cycle, 30 bits). Reset clears all
// protocol state and config to defaults.
// A stalled output holds the result and blocks the next input.
module can_firmware_update_sender_core #(
  parameter int unsigned ChunkBytes      = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfus_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cfus_pkg::rsp_t   out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cfus_pkg::*;

  localparam cfg_t CfgReset = '{node_address: 8'd1, default: '0};

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_NODE:  cfg_q.node_address   <= pwdata[7:0];
        REG_AUX:   cfg_q.image_is_aux   <= pwdata[0];
        REG_KB:    cfg_q.image_kbytes   <= pwdata[12:0];
        REG_READY: cfg_q.ready_frame_id <= pwdata[28:0];
        REG_START: cfg_q.start_frame_id <= pwdata[28:0];
        REG_DATA:  cfg_q.data_frame_id  <= pwdata[28:0];
        REG_END:   cfg_q.end_frame_id   <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (ridx)
      REG_NODE:  prdata = {24'd0, cfg_q.node_address};
      REG_AUX:   prdata = {31'd0, cfg_q.image_is_aux};
      REG_KB:    prdata = {19'd0, cfg_q.image_kbytes};
      REG_READY: prdata = {3'd0, cfg_q.ready_frame_id};
      REG_START: prdata = {3'd0, cfg_q.start_frame_id};
      REG_DATA:  prdata = {3'd0, cfg_q.data_frame_id};
      REG_END:   prdata = {3'd0, cfg_q.end_frame_id};
      default:   prdata = '0;
    endcase
  end

  cfus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfus_dp #(
    .ChunkBytes      (ChunkBytes)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_data_o)
  );
endmodule

### tb/sv/tb.sv
// Testbench for the CAN firmware update sender core: predicts every response.
`timescale 1ns / 100ps

module tb;
  import cfus_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  can_firmware_update_sender_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Sender-side model state
  cfg_t        cfg_m;
  logic [3:0]  phase_m;
  logic [3:0]  retries_m;
  logic [15:0] pkt_cnt_m;
  logic [22:0] left_m;
  logic [22:0] offset_m;
  logic [12:0] cdown_m;
  logic [28:0] last_id_m;
  logic [63:0] last_pl_m;
  logic [2:0]  chunk_len_m;
  logic        active_m;
  logic [6:0]  progress_m;

  req_t pending_q[$];
  rsp_t frame_exp_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   hold_rx = 1'b0;
  int   hold_rx_left = 0;
  bit   hold_tx = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;

  function automatic logic [22:0] image_bytes();
    logic [12:0] k;
    k = (cfg_m.image_kbytes > 13'd4096) ? 13'd4096 : cfg_m.image_kbytes;
    return {k[12:0], 10'd0};
  endfunction

  function automatic logic [63:0] low_bytes(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [28:0] frame_id(logic [28:0] base);
    return base | (29'(cfg_m.node_address) << 8);
  endfunction

  // Emit the frame that is held in last_id/last_pl
  function automatic void put_frame(ref rsp_t r, input logic [3:0] len);
    r.tx_valid = 1'b1;
    r.tx_ident = last_id_m;
    r.tx_length = len;
    r.tx_payload = last_pl_m;
  endfunction

  function automatic void send_data_frame(req_t q, ref rsp_t r);
    if (retries_m > DATA_RETRY_MAX) begin
      retries_m = '0;
      phase_m = PH_NORSP;
      return;
    end
    put_frame(r, 4'(chunk_len_m) + 4'd2);
    if (q.tx_ok) begin
      cdown_m = DATA_WAIT;
      phase_m = PH_WDATA;
    end
    retries_m = retries_m + 4'd1;
  endfunction

  function automatic void protocol_step(req_t q, ref rsp_t r);
    logic [22:0] tot;
    logic [22:0] done;
    int n;
    if (!active_m) return;
    case (phase_m)
      PH_READY, PH_START, PH_END: begin
        if (retries_m > CTRL_RETRY_MAX) begin
          retries_m = '0;
          phase_m = PH_NORSP;
        end else begin
          progress_m = '0;
          pkt_cnt_m = '0;
          if (phase_m == PH_READY) begin
            last_id_m = frame_id(cfg_m.ready_frame_id);
            last_pl_m = 64'(cfg_m.image_is_aux);
          end else if (phase_m == PH_START) begin
            last_id_m = frame_id(cfg_m.start_frame_id);
            last_pl_m = 64'(cfg_m.image_is_aux);
          end else begin
            last_id_m = frame_id(cfg_m.end_frame_id);
            last_pl_m = 64'd1;
          end
          put_frame(r, 4'd8);
          if (q.tx_ok) begin
            phase_m = phase_m + 4'd1;
            cdown_m = CTRL_WAIT;
          end
          retries_m = retries_m + 4'd1;
        end
      end
      PH_WREADY, PH_WSTART, PH_WEND: begin
        if (q.rx_valid && q.rx_ident == last_id_m && q.rx_payload == last_pl_m) begin
          phase_m = phase_m + 4'd1;
          retries_m = '0;
        end else if (cdown_m == 0) begin
          phase_m = phase_m - 4'd1;
        end
      end
      PH_BUILD: begin
        if (left_m == 0) begin
          retries_m = '0;
          phase_m = PH_END;
        end else begin
          n = (left_m > 6) ? 6 : int'(left_m);
          if (pkt_cnt_m[6:0] == 0 && !q.image_read_ok) begin
            phase_m = PH_RDERR;
          end else begin
            chunk_len_m = 3'(n);
            last_id_m = frame_id(cfg_m.data_frame_id);
            last_pl_m = {q.image_chunk & 48'(low_bytes(n)), 1'b0,
                         pkt_cnt_m[6:0], pkt_cnt_m[14:7]};
            phase_m = PH_SEND;
            retries_m = '0;
            send_data_frame(q, r);
          end
        end
      end
      PH_SEND: send_data_frame(q, r);
      PH_WDATA: begin
        if (q.rx_valid && q.rx_ident == last_id_m &&
            ((q.rx_payload ^ last_pl_m) & low_bytes(chunk_len_m)) == 0) begin
          tot = image_bytes();
          pkt_cnt_m = pkt_cnt_m + 16'd1;
          offset_m = offset_m + 23'(chunk_len_m);
          left_m = (left_m < chunk_len_m) ? '0 : left_m - 23'(chunk_len_m);
          done = (tot > left_m) ? tot - left_m : '0;
          progress_m = 7'((64'(done) * 100) / (64'(tot) + 1));
          phase_m = PH_BUILD;
        end else if (cdown_m == 0) begin
          phase_m = PH_SEND;
        end
      end
      default: active_m = 1'b0;
    endcase
  endfunction

  // Predict the response to one accepted transaction
  function automatic rsp_t predict_response(req_t q);
    rsp_t r;
    logic [2:0] st;
    r = '0;
    case (q.req_type)
      REQ_START: begin
        phase_m = PH_READY;
        offset_m = '0;
        left_m = image_bytes();
        retries_m = '0;
        active_m = 1'b1;
      end
      REQ_TICK: cdown_m = (cdown_m > q.elapsed) ? cdown_m - 13'(q.elapsed) : '0;
      REQ_STEP: protocol_step(q, r);
      default: ;
    endcase
    if (phase_m >= 4'd12) st = ST_NORSP;
    else if (phase_m == PH_RDERR) st = ST_RDERR;
    else if (phase_m == PH_NORSP) st = ST_NORSP;
    else if (phase_m == PH_DONE || phase_m == PH_WEND) st = ST_OK;
    else if (!active_m) st = ST_IDLE;
    else if (phase_m == PH_END) st = ST_SENT;
    else st = ST_RUN;
    r.status = st;
    r.percent = (st == ST_SENT || st == ST_OK) ? 7'd100 : progress_m;
    r.next_offset = offset_m;
    r.busy_res = active_m;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR t=%0t %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Drive transactions from the pending queue
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o) begin
      frame_exp_q.push_back(predict_response(in_data_i));
    end
    if (!in_valid_i || in_ready_o) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!hold_tx && pending_q.size() > 0) begin
        in_data_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Check responses and pace the receiver
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (frame_exp_q.size() == 0) begin
        report("unexpected response", out_data_o.tx_payload, 64'd0);
      end else begin
        rsp_t e;
        e = frame_exp_q.pop_front();
        if (out_data_o.tx_valid != e.tx_valid)
          report("tx_valid", 64'(out_data_o.tx_valid), 64'(e.tx_valid));
        if (out_data_o.tx_ident != e.tx_ident)
          report("tx_ident", 64'(out_data_o.tx_ident), 64'(e.tx_ident));
        if (out_data_o.tx_length != e.tx_length)
          report("tx_length", 64'(out_data_o.tx_length), 64'(e.tx_length));
        if (out_data_o.tx_payload != e.tx_payload)
          report("tx_payload", out_data_o.tx_payload, e.tx_payload);
        if (out_data_o.status != e.status)
          report("status", 64'(out_data_o.status), 64'(e.status));
        if (out_data_o.percent != e.percent)
          report("percent", 64'(out_data_o.percent), 64'(e.percent));
        if (out_data_o.next_offset != e.next_offset)
          report("next_offset", 64'(out_data_o.next_offset), 64'(e.next_offset));
        if (out_data_o.busy_res != e.busy_res)
          report("busy_res", 64'(out_data_o.busy_res), 64'(e.busy_res));
      end
    end
    if (hold_rx_left > 0) begin
      hold_rx_left <= hold_rx_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_rx) begin
      hold_rx_left <= 400;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (out_valid_o && out_ready_i)
        rx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycles > 3000000) begin
      $display("can_firmware_update_sender_core: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_NODE:  cfg_m.node_address = val[7:0];
      REG_AUX:   cfg_m.image_is_aux = val[0];
      REG_KB:    cfg_m.image_kbytes = val[12:0];
      REG_READY: cfg_m.ready_frame_id = val[28:0];
      REG_START: cfg_m.start_frame_id = val[28:0];
      REG_DATA:  cfg_m.data_frame_id = val[28:0];
      default:   cfg_m.end_frame_id = val[28:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || frame_exp_q.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic req_t noise_req();
    req_t q;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    if (q.req_type == REQ_START && $urandom_range(0, 7) != 0) q.req_type = REQ_STEP;
    return q;
  endfunction

  function automatic req_t step_req(logic tx_ok);
    req_t q;
    q = noise_req();
    q.req_type = REQ_STEP;
    q.tx_ok = tx_ok;
    q.rx_valid = 1'b0;
    q.image_read_ok = ($urandom_range(0, 40) != 0);
    return q;
  endfunction

  // Echo stimulus: since echo content depends on sent frames, echoes are
  // filled at drive time from the predictor through this flag
  bit echo_mode = 1'b0;

  initial begin
    int i;
    int p;
    req_t q;
    cfg_m = '0;
    cfg_m.node_address = 8'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes of configuration and request fields
    cfg_write(REG_NODE, 32'hff);
    cfg_write(REG_AUX, 32'd1);
    cfg_write(REG_KB, 32'h1fff);
    cfg_write(REG_READY, 32'h1fff_ffff);
    cfg_write(REG_START, 32'd0);
    cfg_write(REG_DATA, 32'h0aaa_0000);
    cfg_write(REG_END, 32'h1555_5555);
    q = '0; q.req_type = REQ_STEP; pending_q.push_back(q);
    q = '1; q.req_type = 2'd3; pending_q.push_back(q);
    q = '1; q.req_type = REQ_TICK; pending_q.push_back(q);
    q = '0; q.req_type = REQ_START; pending_q.push_back(q);
    for (i = 0; i < 12; i++) begin
      q = '1; q.req_type = REQ_STEP; q.tx_ok = (i % 2); q.rx_valid = 1'b0;
      pending_q.push_back(q);
    end
    q = '0; q.req_type = REQ_STEP; pending_q.push_back(q);
    q = '0; q.req_type = REQ_STEP; pending_q.push_back(q);
    wait_drained();

    // Random phases: each uses its own configuration, small images mostly
    for (p = 0; p < 14; p++) begin
      cfg_write(REG_NODE, (p == 1) ? 32'd0 : $urandom_range(0, 255));
      cfg_write(REG_AUX, $urandom_range(0, 1));
      cfg_write(REG_KB, (p == 2) ? 32'd4096 : (p == 3) ? 32'd0 : $urandom_range(1, 2));
      cfg_write(REG_READY, $urandom & 32'h1fff_ffff);
      cfg_write(REG_START, $urandom & 32'h1fff_ffff);
      cfg_write(REG_DATA, $urandom & 32'h1fff_ffff);
      cfg_write(REG_END, $urandom & 32'h1fff_ffff);
      hold_rx = (p == 5);
      echo_mode = 1'b1;
      q = noise_req(); q.req_type = REQ_START; pending_q.push_back(q);
      for (i = 0; i < 110; i++) begin
        case ($urandom_range(0, 19))
          0: pending_q.push_back(noise_req());
          1: begin
            q = noise_req(); q.req_type = REQ_TICK; pending_q.push_back(q);
          end
          default: begin
            q = step_req($urandom_range(0, 7) != 0);
            q.rx_valid = 1'b1; // echo filled by the feeder below
            pending_q.push_back(q);
          end
        endcase
      end
      if (p == 5) begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      if (p == 8) begin
        hold_tx = 1'b1;
        while (frame_exp_q.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_tx = 1'b0;
      end
      wait_drained();
      echo_mode = 1'b0;
    end

    if (errors == 0) begin
      $display("can_firmware_update_sender_core: match");
    end else begin
      $display("can_firmware_update_sender_core: mismatch");
    end
    $finish;
  end

  // Echo feeder: in echo mode rewrite queued rx frames to match what the
  // model last sent, with occasional corruption, so transfers progress
  always @(negedge clk_i) begin
    if (echo_mode && pending_q.size() > 0 && pending_q[0].rx_valid &&
        pending_q[0].req_type == REQ_STEP && !(in_valid_i && !in_ready_o)) begin
      if ($urandom_range(0, 15) != 0) begin
        pending_q[0].rx_ident = last_id_m;
        pending_q[0].rx_payload = (last_pl_m & low_bytes(chunk_len_m)) |
          ((phase_m == PH_WDATA) ? ({$urandom, $urandom} & ~low_bytes(chunk_len_m))
                                 : (last_pl_m & ~low_bytes(chunk_len_m)));
      end
    end
  end

endmodule
